// ----- rtl/rcfd_pkg.sv -----
// Shared types, constants and helpers for the RC receiver frame decoder.
// No dependencies; imported by every module of the block.
package rcfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int FRAME_W     = FRAME_BYTES * 8;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;   // last byte is taken straight from the port
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int STICK_W = 11;
    localparam int WORD_W  = 16;

    localparam logic [STICK_W-1:0] STICK_OFFSET = 11'd1024;
    localparam logic [WORD_W-1:0]  WHEEL_OFFSET = 16'd1024;

    localparam logic [15:0]        GAP_RESET   = 16'd6;
    localparam logic [15:0]        DISC_RESET  = 16'd100;
    localparam logic [STICK_W-1:0] LIMIT_RESET = 11'd660;

    // configuration register indexes (byte address = 4 * index)
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_GAP   = 2'd0;
    localparam logic [1:0] REG_DISC  = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    // input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // switch position codes on the wire and as reported
    localparam logic [1:0] SW_RAW_UP   = 2'd1;
    localparam logic [1:0] SW_RAW_MID  = 2'd3;
    localparam logic [1:0] SW_RAW_DOWN = 2'd2;
    localparam logic [1:0] SW_UNKNOWN  = 2'd0;
    localparam logic [1:0] SW_UP       = 2'd1;
    localparam logic [1:0] SW_MID      = 2'd2;
    localparam logic [1:0] SW_DOWN     = 2'd3;

    typedef enum logic {
        EV_FRAME = 1'b0,
        EV_LOST  = 1'b1
    } t_ev_op;

    typedef struct packed {
        t_ev_op             op;
        logic [FRAME_W-1:0] frame;
    } t_event;

    function automatic logic [1:0] map_switch(input logic [1:0] raw);
        logic [1:0] code;
        unique case (raw)
            SW_RAW_UP:   code = SW_UP;
            SW_RAW_MID:  code = SW_MID;
            SW_RAW_DOWN: code = SW_DOWN;
            default:     code = SW_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/rcfd_front.sv -----
// Front end: accepts bytes and ticks, assembles the frame, tracks silence and link.
// Emits a frame-complete or link-lost event into the queue. Uses rcfd_pkg.
module rcfd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_command,
    input  logic [7:0]             i_rx_byte,
    input  logic [15:0]            i_gap_timeout,
    input  logic [15:0]            i_disc_timeout,
    output logic                   o_push,
    output rcfd_pkg::t_event       o_event
);
    import rcfd_pkg::*;

    logic [7:0]       r_frame [STORE_DEPTH];
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_silence, n_silence;
    logic             r_link, n_link;
    logic [15:0]      silence_inc;
    logic [FRAME_W-1:0] frame_flat;

    for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_pack
        assign frame_flat[8*k +: 8] = r_frame[k];
    end
    assign frame_flat[FRAME_W-1 -: 8] = i_rx_byte;

    // silence counter saturates
    assign silence_inc = (r_silence != 16'hFFFF) ? r_silence + 16'd1 : r_silence;

    always_comb begin
        n_count        = r_count;
        n_silence      = r_silence;
        n_link         = r_link;
        o_push         = 1'b0;
        o_event.op     = EV_FRAME;
        o_event.frame  = frame_flat;
        if (i_accept) begin
            if (i_command == CMD_TICK) begin
                n_silence = silence_inc;
                if (silence_inc > i_disc_timeout) begin
                    n_link  = 1'b0;
                    n_count = '0;
                    // values are already clear while the link is down
                    if (r_link) begin
                        o_push     = 1'b1;
                        o_event.op = EV_LOST;
                    end
                end
                if (silence_inc > i_gap_timeout) begin
                    n_count = '0;
                end
            end else begin
                n_silence = '0;
                if (r_count == LAST_IDX) begin
                    n_count = '0;
                    n_link  = 1'b1;
                    o_push  = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_silence <= '0;
            r_link    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_silence <= n_silence;
            r_link    <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_command == CMD_BYTE && r_count != LAST_IDX) begin
            r_frame[r_count] <= i_rx_byte;
        end
    end

`ifndef SYNTHESIS
    a_byte_clears_silence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_command == CMD_BYTE) |=> (r_silence == '0))
        else $error("silence not cleared by a received byte");
    a_lost_only_when_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_event.op == EV_LOST) |-> (r_link && !n_link))
        else $error("link-lost event without the link going down");
`endif

endmodule

// ----- rtl/rcfd_queue.sv -----
// Short event queue between the front end and the decoder back end.
// Register-based FIFO of rcfd_pkg::t_event entries. Uses rcfd_pkg.
module rcfd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  rcfd_pkg::t_event       i_event,
    output logic                   o_not_full,
    input  logic                   i_pop,
    output logic                   o_valid,
    output rcfd_pkg::t_event       o_event
);
    import rcfd_pkg::*;

    t_event            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_not_full = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_event    = r_mem[r_rd];
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_event;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_not_full)
        else $error("event pushed into a full queue");
`endif

endmodule

// ----- rtl/rcfd_back.sv -----
// Back end: unpacks a completed frame or clears on link loss, holds the decoded
// values and presents them as the result item. Uses rcfd_pkg.
module rcfd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rcfd_pkg::t_event              i_event,
    output logic                          o_pop,
    input  logic [rcfd_pkg::STICK_W-1:0]  i_stick_limit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rcfd_pkg::STICK_W-1:0]  o_stick [4],
    output logic [3:0]                    o_switch_codes,
    output logic [rcfd_pkg::WORD_W-1:0]   o_mouse [3],
    output logic [1:0]                    o_mouse_buttons,
    output logic [15:0]                   o_key_mask,
    output logic [rcfd_pkg::WORD_W-1:0]   o_wheel,
    output logic                          o_link_up
);
    import rcfd_pkg::*;

    logic [7:0]         b [FRAME_BYTES];
    logic [STICK_W-1:0] raw [4];
    logic [STICK_W-1:0] mag [4];
    logic [3:0]         over;
    logic               in_range;

    logic               r_valid;
    logic [STICK_W-1:0] r_stick [4];
    logic [3:0]         r_switch;
    logic [WORD_W-1:0]  r_mouse [3];
    logic [1:0]         r_buttons;
    logic [15:0]        r_keys;
    logic [WORD_W-1:0]  r_wheel;
    logic               r_link;

    for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_bytes
        assign b[k] = i_event.frame[8*k +: 8];
    end

    // 11-bit channels packed LSB first across bytes 0..5
    assign raw[0] = {b[1][2:0], b[0]};
    assign raw[1] = {b[2][5:0], b[1][7:3]};
    assign raw[2] = {b[4][0], b[3], b[2][7:6]};
    assign raw[3] = {b[5][3:0], b[4][7:1]};

    for (genvar s = 0; s < 4; s++) begin : g_mag
        assign mag[s]  = raw[s][STICK_W-1] ? {1'b0, raw[s][STICK_W-2:0]} : STICK_OFFSET - raw[s];
        assign over[s] = (mag[s] > i_stick_limit);
    end
    assign in_range = (over == '0);

    // take a new event when the result slot is empty or being drained
    assign o_pop = i_valid && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_stick   <= '{default: '0};
            r_switch  <= '0;
            r_mouse   <= '{default: '0};
            r_buttons <= '0;
            r_keys    <= '0;
            r_wheel   <= '0;
            r_link    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_event.op)
                    EV_LOST: begin
                        r_stick   <= '{default: '0};
                        r_switch  <= '0;
                        r_mouse   <= '{default: '0};
                        r_buttons <= '0;
                        r_keys    <= '0;
                        r_wheel   <= '0;
                        r_link    <= 1'b0;
                    end
                    EV_FRAME: begin
                        r_link <= 1'b1;
                        for (int s = 0; s < 4; s++) begin
                            r_stick[s] <= raw[s] ^ STICK_OFFSET;
                        end
                        r_switch <= {map_switch(b[5][7:6]), map_switch(b[5][5:4])};
                        if (in_range) begin
                            r_mouse[0] <= {b[7], b[6]};
                            r_mouse[1] <= {b[9], b[8]};
                            r_mouse[2] <= {b[11], b[10]};
                            r_buttons  <= {b[13] != 8'd0, b[12] != 8'd0};
                            r_keys     <= {b[15], b[14]};
                            r_wheel    <= {b[17], b[16]} - WHEEL_OFFSET;
                        end
                    end
                    default: r_link <= r_link;
                endcase
            end
        end
    end

    assign o_out_valid     = r_valid;
    assign o_stick         = r_stick;
    assign o_switch_codes  = r_switch;
    assign o_mouse         = r_mouse;
    assign o_mouse_buttons = r_buttons;
    assign o_key_mask      = r_keys;
    assign o_wheel         = r_wheel;
    assign o_link_up       = r_link;

`ifndef SYNTHESIS
    a_frame_sets_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_event.op == EV_FRAME) |=> (o_out_valid && o_link_up))
        else $error("decoded frame did not raise link");
    a_lost_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_event.op == EV_LOST) |=>
            (o_out_valid && !o_link_up && o_key_mask == '0 && o_switch_codes == '0))
        else $error("link loss did not clear values");
`endif

endmodule

// ----- rtl/rc_receiver_frame_decoder.sv -----
// RC receiver frame decoder top level: configuration registers, front end,
// event queue and decoder back end. Uses rcfd_pkg, rcfd_front, rcfd_queue, rcfd_back.
// Throughput: one item (byte or tick) per cycle; input stalls only while the queue is full.
// A result is queued, then decoded into the output register when that slot is free.
// Reset: synchronous active-low; clears counters, link and all decoded values and
// loads the timeout and limit registers with their defaults.
module rc_receiver_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_command,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [10:0]            o_right_stick_x,
    output logic signed [10:0]            o_right_stick_y,
    output logic signed [10:0]            o_left_stick_x,
    output logic signed [10:0]            o_left_stick_y,
    output logic [3:0]                    o_switch_codes,
    output logic signed [15:0]            o_mouse_x,
    output logic signed [15:0]            o_mouse_y,
    output logic signed [15:0]            o_mouse_z,
    output logic [1:0]                    o_mouse_buttons,
    output logic [15:0]                   o_key_mask,
    output logic signed [15:0]            o_wheel,
    output logic                          o_link_up,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcfd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rcfd_pkg::*;

    logic [15:0]        r_gap, r_disc;
    logic [STICK_W-1:0] r_limit;
    logic               wr_en;
    logic [1:0]         reg_idx;

    logic               accept;
    logic               push, q_not_full, q_valid, pop;
    t_event             push_ev, head_ev;
    logic [STICK_W-1:0] stick [4];
    logic [WORD_W-1:0]  mouse [3];
    logic [WORD_W-1:0]  wheel;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= GAP_RESET;
            r_disc  <= DISC_RESET;
            r_limit <= LIMIT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_GAP:   r_gap   <= pwdata[15:0];
                REG_DISC:  r_disc  <= pwdata[15:0];
                REG_LIMIT: r_limit <= pwdata[STICK_W-1:0];
                default:   r_gap   <= r_gap;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GAP:   prdata = {16'd0, r_gap};
            REG_DISC:  prdata = {16'd0, r_disc};
            REG_LIMIT: prdata = {{(32-STICK_W){1'b0}}, r_limit};
            default:   prdata = '0;
        endcase
    end

    assign o_in_ready = q_not_full;
    assign accept     = i_in_valid && o_in_ready;

    rcfd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_command      (i_command),
        .i_rx_byte      (i_rx_byte),
        .i_gap_timeout  (r_gap),
        .i_disc_timeout (r_disc),
        .o_push         (push),
        .o_event        (push_ev)
    );

    rcfd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_event    (push_ev),
        .o_not_full (q_not_full),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_event    (head_ev)
    );

    rcfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_event         (head_ev),
        .o_pop           (pop),
        .i_stick_limit   (r_limit),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_stick         (stick),
        .o_switch_codes  (o_switch_codes),
        .o_mouse         (mouse),
        .o_mouse_buttons (o_mouse_buttons),
        .o_key_mask      (o_key_mask),
        .o_wheel         (wheel),
        .o_link_up       (o_link_up)
    );

    assign o_right_stick_x = $signed(stick[0]);
    assign o_right_stick_y = $signed(stick[1]);
    assign o_left_stick_x  = $signed(stick[2]);
    assign o_left_stick_y  = $signed(stick[3]);
    assign o_mouse_x       = $signed(mouse[0]);
    assign o_mouse_y       = $signed(mouse[1]);
    assign o_mouse_z       = $signed(mouse[2]);
    assign o_wheel         = $signed(wheel);

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rc_receiver_frame_decoder: byte and tick items
// in, decoded frame / link-loss results out, checked against an in-bench predictor.
// Depends on rcfd_pkg and the decoder RTL only.
module tb;
    import rcfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 200;

    typedef struct packed {
        logic [10:0] right_h;
        logic [10:0] right_v;
        logic [10:0] left_h;
        logic [10:0] left_v;
        logic [3:0]  switches;
        logic [15:0] mouse_x;
        logic [15:0] mouse_y;
        logic [15:0] mouse_z;
        logic [1:0]  buttons;
        logic [15:0] keys;
        logic [15:0] wheel;
        logic        link;
    } t_rc_values;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_command;
    logic [7:0]         i_rx_byte;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [10:0] o_right_stick_x;
    logic signed [10:0] o_right_stick_y;
    logic signed [10:0] o_left_stick_x;
    logic signed [10:0] o_left_stick_y;
    logic [3:0]         o_switch_codes;
    logic signed [15:0] o_mouse_x;
    logic signed [15:0] o_mouse_y;
    logic signed [15:0] o_mouse_z;
    logic [1:0]         o_mouse_buttons;
    logic [15:0]        o_key_mask;
    logic signed [15:0] o_wheel;
    logic               o_link_up;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    rc_receiver_frame_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_right_stick_x (o_right_stick_x),
        .o_right_stick_y (o_right_stick_y),
        .o_left_stick_x  (o_left_stick_x),
        .o_left_stick_y  (o_left_stick_y),
        .o_switch_codes  (o_switch_codes),
        .o_mouse_x       (o_mouse_x),
        .o_mouse_y       (o_mouse_y),
        .o_mouse_z       (o_mouse_z),
        .o_mouse_buttons (o_mouse_buttons),
        .o_key_mask      (o_key_mask),
        .o_wheel         (o_wheel),
        .o_link_up       (o_link_up),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder state as predicted
    logic [7:0]  frame_buf [FRAME_BYTES];
    int          rx_count = 0;
    logic [15:0] quiet_ms = '0;
    t_rc_values  decoded  = '0;
    logic [15:0] cfg_gap   = GAP_RESET;
    logic [15:0] cfg_disc  = DISC_RESET;
    logic [10:0] cfg_limit = LIMIT_RESET;

    t_rc_values  rc_expected [$];

    bit send_idle;
    bit sink_idle;
    int fail_count  = 0;
    int n_items     = 0;
    int n_frames    = 0;
    int n_losses    = 0;
    int n_checked   = 0;
    int n_settings  = 0;
    int cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [1:0] switch_code(input logic [1:0] raw);
        case (raw)
            SW_RAW_UP:   return SW_UP;
            SW_RAW_MID:  return SW_MID;
            SW_RAW_DOWN: return SW_DOWN;
            default:     return SW_UNKNOWN;
        endcase
    endfunction

    // Advance the predicted state by one accepted item; queue any result it causes.
    task automatic apply_item(input logic cmd, input logic [7:0] data);
        logic [10:0] raw [4];
        logic        sticks_ok;
        logic        was_up;
        int          value;
        n_items++;
        if (cmd == CMD_TICK) begin
            if (quiet_ms != 16'hFFFF)
                quiet_ms++;
            if (quiet_ms > cfg_disc) begin
                was_up   = decoded.link;
                decoded  = '0;
                rx_count = 0;
                if (was_up) begin
                    rc_expected.push_back(decoded);
                    n_losses++;
                end
            end
            if (quiet_ms > cfg_gap)
                rx_count = 0;
        end else begin
            if (rx_count >= FRAME_BYTES)
                rx_count = 0;
            frame_buf[rx_count] = data;
            rx_count++;
            quiet_ms = '0;
            if (rx_count == FRAME_BYTES) begin
                rx_count = 0;
                decoded.link = 1'b1;
                raw[0] = {frame_buf[1][2:0], frame_buf[0]};
                raw[1] = {frame_buf[2][5:0], frame_buf[1][7:3]};
                raw[2] = {frame_buf[4][0], frame_buf[3], frame_buf[2][7:6]};
                raw[3] = {frame_buf[5][3:0], frame_buf[4][7:1]};
                sticks_ok = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    value = int'(raw[i]) - int'(STICK_OFFSET);
                    if ((value < 0 ? -value : value) > int'(cfg_limit))
                        sticks_ok = 1'b0;
                end
                decoded.right_h  = raw[0] - STICK_OFFSET;
                decoded.right_v  = raw[1] - STICK_OFFSET;
                decoded.left_h   = raw[2] - STICK_OFFSET;
                decoded.left_v   = raw[3] - STICK_OFFSET;
                decoded.switches = {switch_code(frame_buf[5][7:6]),
                                    switch_code(frame_buf[5][5:4])};
                // out-of-range sticks freeze mouse, buttons, keys and wheel
                if (sticks_ok) begin
                    decoded.mouse_x = {frame_buf[7], frame_buf[6]};
                    decoded.mouse_y = {frame_buf[9], frame_buf[8]};
                    decoded.mouse_z = {frame_buf[11], frame_buf[10]};
                    decoded.buttons = {frame_buf[13] != 8'd0, frame_buf[12] != 8'd0};
                    decoded.keys    = {frame_buf[15], frame_buf[14]};
                    decoded.wheel   = {frame_buf[17], frame_buf[16]} - WHEEL_OFFSET;
                end
                rc_expected.push_back(decoded);
                n_frames++;
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_rc_values got;
        t_rc_values want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_right_stick_x, o_right_stick_y, o_left_stick_x,
                   o_left_stick_y, o_switch_codes, o_mouse_x, o_mouse_y, o_mouse_z,
                   o_mouse_buttons, o_key_mask, o_wheel, o_link_up};
            n_checked++;
            if (rc_expected.size() == 0) begin
                $error("result with no item waiting for it");
                fail_count++;
            end else begin
                want = rc_expected.pop_front();
                check_field("right_stick_x", want.right_h, got.right_h);
                check_field("right_stick_y", want.right_v, got.right_v);
                check_field("left_stick_x", want.left_h, got.left_h);
                check_field("left_stick_y", want.left_v, got.left_v);
                check_field("switch_codes", want.switches, got.switches);
                check_field("mouse_x", want.mouse_x, got.mouse_x);
                check_field("mouse_y", want.mouse_y, got.mouse_y);
                check_field("mouse_z", want.mouse_z, got.mouse_z);
                check_field("mouse_buttons", want.buttons, got.buttons);
                check_field("key_mask", want.keys, got.keys);
                check_field("wheel", want.wheel, got.wheel);
                check_field("link_up", want.link, got.link);
            end
        end
    end

    // result sink: random stall before each result while sink_idle is set
    initial begin : result_sink
        int stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = sink_idle ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // Valid stays high across back-to-back items; it drops when a gap is drawn or in settle().
    task automatic send_item(input logic cmd, input logic [7:0] data);
        int gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_rx_byte  <= data;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        apply_item(cmd, data);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(CMD_TICK, 8'($urandom));
    endtask

    // wait for every outstanding result, then for the pipeline to go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rc_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        logic [31:0] mask;
        logic [31:0] readback;
        mask    = (index == REG_LIMIT) ? 32'h7FF : 32'hFFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_GAP:   cfg_gap   = value;
            REG_DISC:  cfg_disc  = value;
            REG_LIMIT: cfg_limit = value[10:0];
            default:   ;
        endcase
        @(posedge i_clk);
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if ((readback & mask) !== (32'(value) & mask)) begin
            $error("register %0d: expected %0h, got %0h", index, 32'(value) & mask,
                   readback & mask);
            fail_count++;
        end
    endtask

    task automatic set_config(input logic [15:0] gap_ms, input logic [15:0] disc_ms,
                              input logic [10:0] limit);
        settle();
        write_reg(REG_GAP, gap_ms);
        write_reg(REG_DISC, disc_ms);
        write_reg(REG_LIMIT, 16'(limit));
        n_settings++;
    endtask

    function automatic logic [FRAME_W-1:0] pack_frame(
        input logic [10:0] s0, input logic [10:0] s1, input logic [10:0] s2,
        input logic [10:0] s3, input logic [1:0] sw_left, input logic [1:0] sw_right,
        input logic [95:0] tail);
        logic [FRAME_W-1:0] f;
        f[7:0]    = s0[7:0];
        f[15:8]   = {s1[4:0], s0[10:8]};
        f[23:16]  = {s2[1:0], s1[10:5]};
        f[31:24]  = s2[9:2];
        f[39:32]  = {s3[6:0], s2[10]};
        f[47:40]  = {sw_left, sw_right, s3[10:7]};
        f[143:48] = tail;
        return f;
    endfunction

    function automatic logic [FRAME_W-1:0] random_frame(input bit in_range);
        logic [10:0] s [4];
        logic [95:0] tail;
        int          mag;
        int          lim;
        lim = (cfg_limit > 11'd1024) ? 1024 : int'(cfg_limit);
        for (int i = 0; i < 4; i++) begin
            if (in_range) begin
                case ($urandom_range(0, 3))
                    0:       mag = 0;
                    1:       mag = lim;
                    default: mag = $urandom_range(0, lim);
                endcase
                s[i] = $urandom_range(0, 1) ? STICK_OFFSET + 11'(mag)
                                            : STICK_OFFSET - 11'(mag);
            end else begin
                s[i] = 11'($urandom);
            end
        end
        // just past the limit on one stick
        if (!in_range && lim < 1024 && $urandom_range(0, 1) == 1)
            s[$urandom_range(0, 3)] = STICK_OFFSET + 11'(lim + 1);
        tail = {$urandom, $urandom, $urandom};
        if ($urandom_range(0, 2) == 0)
            tail[55:48] = 8'd0;
        if ($urandom_range(0, 2) == 0)
            tail[63:56] = 8'd0;
        return pack_frame(s[0], s[1], s[2], s[3], 2'($urandom), 2'($urandom), tail);
    endfunction

    // ticks between bytes stay within tick_room so the frame survives
    task automatic send_frame(input logic [FRAME_W-1:0] bytes, input int tick_room);
        for (int j = 0; j < FRAME_BYTES; j++) begin
            send_item(CMD_BYTE, bytes[8*j +: 8]);
            if (j < FRAME_BYTES - 1 && tick_room > 0 && $urandom_range(0, 9) == 0)
                send_ticks($urandom_range(1, tick_room));
        end
    endtask

    // get back to a frame boundary before a well-formed frame
    task automatic realign();
        if (rx_count != 0) begin
            if (cfg_gap < 40)
                send_ticks(int'(cfg_gap) + 1);
            else
                repeat (FRAME_BYTES - rx_count) send_item(CMD_BYTE, 8'($urandom));
        end
    endtask

    task automatic test_directed();
        set_config(16'd1, 16'd3, 11'd1024);
        // stick extremes, switches down/up, mouse and wheel word extremes
        send_frame(pack_frame(11'd0, 11'd2047, STICK_OFFSET, STICK_OFFSET + LIMIT_RESET,
                              SW_RAW_DOWN, SW_RAW_UP, 96'h0000_FFFF_FF00_FFFF_7FFF_8000), 0);
        // gap drop, link loss, then a repeated clear with nothing reported
        send_ticks(5);
    endtask

    task automatic run_phase(input logic [15:0] gap_ms, input logic [15:0] disc_ms,
                             input logic [10:0] limit, input bit idle_src,
                             input bit idle_dst);
        int first;
        int room;
        int pick;
        set_config(gap_ms, disc_ms, limit);
        send_idle = idle_src;
        sink_idle = idle_dst;
        room = (cfg_gap < cfg_disc) ? int'(cfg_gap) : int'(cfg_disc);
        if (room > 3)
            room = 3;
        first = n_items;
        while (n_items - first < PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                realign();
                send_frame(random_frame($urandom_range(0, 1)), room);
            end else if (pick < 15) begin
                repeat ($urandom_range(1, FRAME_BYTES - 1)) send_item(CMD_BYTE, 8'($urandom));
                if (cfg_gap < 40)
                    send_ticks(int'(cfg_gap) + 1);
            end else if (pick < 17) begin
                if (cfg_disc <= 120)
                    send_ticks(int'(cfg_disc) + 1 + $urandom_range(0, 2));
            end else if (pick < 19) begin
                repeat ($urandom_range(1, 4)) send_item(1'($urandom), 8'($urandom));
            end else begin
                settle();
            end
        end
    endtask

    task automatic test_random_phases();
        run_phase(GAP_RESET, DISC_RESET, LIMIT_RESET, 1'b1, 1'b1);
        run_phase(16'd0, 16'd0, 11'd0, 1'b1, 1'b0);
        run_phase(16'hFFFF, 16'd20, 11'd1024, 1'b0, 1'b1);
        run_phase(16'd3, 16'd12, 11'd300, 1'b0, 1'b0);
        run_phase(16'd10, 16'd5, 11'd1000, 1'b1, 1'b1);
        run_phase(16'd2, 16'hFFFF, 11'd512, 1'b1, 1'b1);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_command  <= CMD_BYTE;
        i_rx_byte  <= 8'd0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        send_idle  = 1'b1;
        sink_idle  = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phases();
        settle();

        $display("tb: %0d items sent under %0d register settings", n_items, n_settings);
        $display("tb: %0d results checked (%0d frames decoded, %0d link losses)",
                 n_checked, n_frames, n_losses);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
